>>> rtl/zbm_pkg.sv
package zbm_pkg;

  localparam int unsigned TAG_W = 32;
  localparam int unsigned BLK_W = 6;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MASK = 8'd3;

  localparam logic RST_ENABLE = 1'b1;
  localparam logic [4:0] RST_PAGE_SHIFT = 5'd12;
  localparam logic [4:0] RST_BLOCK_SHIFT = 5'd6;
  localparam logic [5:0] RST_BLOCK_MASK = 6'd63;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
  } entry_t;

  typedef struct packed {
    logic pre;
    logic md;
  } carry_t;

  typedef enum logic [7:0] {
    ST_CLR  = 8'b0000_0001,
    ST_IDLE = 8'b0000_0010,
    ST_L1   = 8'b0000_0100,
    ST_VIC  = 8'b0000_1000,
    ST_REF  = 8'b0001_0000,
    ST_MAP  = 8'b0010_0000,
    ST_WR   = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

endpackage

>>> rtl/zbm_if.sv
interface zbm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] address;
  logic        new_bit;
  modport source (output valid, mode, address, new_bit, input ready);
  modport sink (input valid, mode, address, new_bit, output ready);
endinterface

interface zbm_out_if;
  logic valid;
  logic ready;
  logic block_bit;
  logic first_level_hit;
  logic second_level_used;
  logic second_level_hit;
  logic second_level_writeback;
  modport source (output valid, block_bit, first_level_hit, second_level_used,
                  second_level_hit, second_level_writeback, input ready);
  modport sink (input valid, block_bit, first_level_hit, second_level_used,
                second_level_hit, second_level_writeback, output ready);
endinterface

interface zbm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/zbm_cell.sv
module zbm_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  upd,
  input  logic                  hit_all,
  input  logic [31:0]           look_tag,
  input  zbm_pkg::carry_t       carry_in,
  input  zbm_pkg::entry_t       next_entry,
  output zbm_pkg::carry_t       carry_out,
  output zbm_pkg::entry_t       entry
);
  import zbm_pkg::*;

  entry_t entry_r;
  logic   match;

  assign match = entry_r.valid && (entry_r.tag == look_tag);
  assign carry_out.pre = carry_in.pre | match;
  assign carry_out.md = carry_in.md | (match & entry_r.dirty);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (upd && (!hit_all || carry_out.pre)) begin
      entry_r <= next_entry;
    end
  end

endmodule

>>> rtl/zbm_chain.sv
module zbm_chain #(
  parameter int unsigned WAYS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  logic [31:0]     look_tag,
  input  logic            dirty_in,
  output logic            hit,
  output zbm_pkg::entry_t victim
);
  import zbm_pkg::*;

  // position 0 least recent, top most recent
  carry_t carry [WAYS+1];
  entry_t ent [WAYS];
  entry_t top_entry;

  assign carry[0] = '0;
  assign hit = carry[WAYS].pre;
  assign victim = ent[0];
  assign top_entry = '{tag: look_tag, valid: 1'b1, dirty: dirty_in | carry[WAYS].md};

  for (genvar i = 0; i < WAYS; i++) begin : g_cell
    entry_t nxt;
    if (i == WAYS - 1) begin : g_top
      assign nxt = top_entry;
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    zbm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (upd),
      .hit_all   (hit),
      .look_tag  (look_tag),
      .carry_in  (carry[i]),
      .next_entry(nxt),
      .carry_out (carry[i+1]),
      .entry     (ent[i])
    );
  end

endmodule

>>> rtl/zero_block_map_two_level_tlb.sv
// Two-level TLB-fronted per-page block bitmap. Each L1 and L2 tag cache is a
// row of cells kept in recency order: a touched entry moves to the top and the
// cells above it shift down one place, so the least recent entry sits at the
// bottom as victim. One item at a time: ST_L1, ST_MAP, ST_WR, ST_DONE on an L1
// hit; a miss adds ST_REF, an update with a dirty L1 victim adds ST_VIC before
// it to write L2, and an update while disabled goes to ST_DONE. The result
// holds until taken; ST_IDLE then takes the next item, as the sequencer and
// single bitmap port set. The page tag's low bits pick the bitmap word, so
// MAP_PAGES must be a power of two, not checked by the block. After reset a
// clearing pass writes MAP_PAGES words, one per cycle, before any item is taken.
module zero_block_map_two_level_tlb #(
  parameter int unsigned L1_WAYS = 16,
  parameter int unsigned L2_WAYS = 64,
  parameter int unsigned MAP_PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  zbm_in_if.sink      in_ch,
  zbm_out_if.source   out_ch,
  zbm_cfg_if.sink     cfg_ch
);
  import zbm_pkg::*;

  localparam int unsigned PAGE_W = (MAP_PAGES > 1) ? $clog2(MAP_PAGES) : 1;
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(MAP_PAGES - 1);

  state_t state_r, state_nxt;

  logic       enable_r;
  logic [4:0] page_shift_r, block_shift_r;
  logic [5:0] block_mask_r;

  logic              mode_r, nb_r;
  logic [TAG_W-1:0]  tag_r, vtag_r;
  logic [BLK_W-1:0]  blk_r;
  logic [PAGE_W-1:0] page_r, clr_cnt_r, mem_addr;

  logic bit_r, l1hit_r, used_r, l2hit_r, wb_r;

  logic [WORD_W-1:0] mem [MAP_PAGES];
  logic [WORD_W-1:0] rdata_r, wdata;
  logic              mem_we;

  logic       l1_hit, l2_hit, l2_upd, l2_dirty_in;
  logic [TAG_W-1:0] l2_look, tag_in, blk_sh;
  entry_t     l1_vic, l2_vic;

  logic accept;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = (state_r == ST_DONE);
  assign out_ch.block_bit = bit_r;
  assign out_ch.first_level_hit = l1hit_r;
  assign out_ch.second_level_used = used_r;
  assign out_ch.second_level_hit = l2hit_r;
  assign out_ch.second_level_writeback = wb_r;

  assign tag_in = in_ch.address >> page_shift_r;
  assign blk_sh = in_ch.address >> block_shift_r;

  zbm_chain #(.WAYS(L1_WAYS)) u_l1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (state_r == ST_L1),
    .look_tag(tag_r),
    .dirty_in(mode_r),
    .hit     (l1_hit),
    .victim  (l1_vic)
  );

  assign l2_upd = (state_r == ST_VIC) || (state_r == ST_REF);
  assign l2_dirty_in = (state_r == ST_VIC);
  assign l2_look = (state_r == ST_VIC) ? vtag_r : tag_r;

  zbm_chain #(.WAYS(L2_WAYS)) u_l2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (l2_upd),
    .look_tag(l2_look),
    .dirty_in(l2_dirty_in),
    .hit     (l2_hit),
    .victim  (l2_vic)
  );

  // bitmap store
  assign mem_addr = (state_r == ST_CLR) ? clr_cnt_r : page_r;
  assign mem_we = (state_r == ST_CLR) || ((state_r == ST_WR) && mode_r);
  always_comb begin
    wdata = rdata_r;
    wdata[blk_r] = nb_r;
    if (state_r == ST_CLR) wdata = '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wdata;
    rdata_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (clr_cnt_r == LAST_PAGE) state_nxt = ST_IDLE;
      ST_IDLE: if (accept) state_nxt = (in_ch.mode && !enable_r) ? ST_DONE : ST_L1;
      ST_L1: begin
        if (l1_hit) state_nxt = ST_MAP;
        else if (l1_vic.dirty && mode_r) state_nxt = ST_VIC;
        else state_nxt = ST_REF;
      end
      ST_VIC:  state_nxt = ST_REF;
      ST_REF:  state_nxt = ST_MAP;
      ST_MAP:  state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_DONE;
      ST_DONE: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_cnt_r <= '0;
      enable_r <= RST_ENABLE;
      page_shift_r <= RST_PAGE_SHIFT;
      block_shift_r <= RST_BLOCK_SHIFT;
      block_mask_r <= RST_BLOCK_MASK;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_cnt_r <= clr_cnt_r + PAGE_W'(1);
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_ENABLE:      enable_r <= cfg_ch.data[0];
          REG_PAGE_SHIFT:  page_shift_r <= cfg_ch.data[4:0];
          REG_BLOCK_SHIFT: block_shift_r <= cfg_ch.data[4:0];
          REG_BLOCK_MASK:  block_mask_r <= cfg_ch.data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (accept) begin
        mode_r <= in_ch.mode;
        nb_r <= in_ch.new_bit;
        tag_r <= tag_in;
        page_r <= tag_in[PAGE_W-1:0];
        blk_r <= blk_sh[BLK_W-1:0] & block_mask_r;
        bit_r <= 1'b0;
        l1hit_r <= 1'b0;
        used_r <= 1'b0;
        l2hit_r <= 1'b0;
        wb_r <= 1'b0;
      end
      ST_L1: begin
        l1hit_r <= l1_hit;
        used_r <= !l1_hit;
        vtag_r <= l1_vic.tag;
      end
      ST_VIC: if (!l2_hit && l2_vic.dirty) wb_r <= 1'b1;
      ST_REF: begin
        l2hit_r <= l2_hit;
        if (!l2_hit && l2_vic.dirty) wb_r <= 1'b1;
      end
      ST_WR: bit_r <= mode_r ? 1'b1 : (enable_r ? rdata_r[blk_r] : 1'b1);
      default: ;
    endcase
  end

endmodule

>>> rtl/zbm_checker.sv
module zbm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic first_level_hit,
  input logic second_level_used,
  input logic second_level_hit,
  input logic second_level_writeback
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_l1_hit_no_l2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_level_hit |-> !second_level_used)
    else $error("l2 used on l1 hit");

  a_l2_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (second_level_hit || second_level_writeback) |-> second_level_used)
    else $error("l2 flag without l2 refill");

endmodule

bind zero_block_map_two_level_tlb zbm_checker u_zbm_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .first_level_hit       (out_ch.first_level_hit),
  .second_level_used     (out_ch.second_level_used),
  .second_level_hit      (out_ch.second_level_hit),
  .second_level_writeback(out_ch.second_level_writeback)
);
